### hw/rtl/rfwe_pkg.sv
// Types and constants shared by the rational-fit weighted-error block.
`default_nettype none

package rfwe_pkg;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV1_GO,
		ST_DIV1,
		ST_SGN,
		ST_ABS,
		ST_SQR,
		ST_DIV2_GO,
		ST_DIV2,
		ST_ACC,
		ST_FIN
	} rfwe_state_t;

	typedef enum logic [1:0] {
		DS_IDLE,
		DS_CHECK,
		DS_RUN,
		DS_DONE
	} div_state_t;

	typedef enum logic [2:0] {
		MS_KK,
		MS_BK,
		MS_CKK,
		MS_DK,
		MS_EKK,
		MS_DRAIN
	} mul_step_t;

	typedef enum logic [2:0] {
		REG_COEF_A = 3'd0,
		REG_COEF_B = 3'd1,
		REG_COEF_C = 3'd2,
		REG_COEF_D = 3'd3,
		REG_COEF_E = 3'd4
	} cfg_reg_t;

	localparam logic [63:0] DEN_ONE    = 64'h0001_0000_0000_0000;
	localparam logic [40:0] MODEL_CAP  = 41'h100_0000_0000;
	localparam logic [31:0] RES_CAP    = 32'hFFFF_FFFF;
	localparam logic [6:0]  DIV1_ITERS = 7'd40;
	localparam logic [6:0]  DIV2_ITERS = 7'd64;

	typedef struct packed {
		logic        start;
		logic [63:0] rem;
		logic [63:0] bits;
		logic [63:0] divisor;
		logic [6:0]  iters;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic        ovf;
		logic [63:0] quot;
	} div_rsp_t;

endpackage

`default_nettype wire

### hw/rtl/rfwe_div.sv
// Radix-2 restoring divider shared by the model ratio and the spread weighting.
`default_nettype none

module rfwe_div
	import rfwe_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire div_req_t req,
	output div_rsp_t      rsp
);

	div_state_t  state_q, state_d;
	logic [6:0]  cnt_q;
	logic [63:0] rem_q;
	logic [63:0] bits_q;
	logic [63:0] dvs_q;
	logic [63:0] quot_q;
	logic        ovf_q;
	logic [63:0] trial;
	logic        fits;

	// remainder stays below the divisor, so its top bit is always clear
	assign trial = {rem_q[62:0], bits_q[63]};
	assign fits  = (trial >= dvs_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			DS_IDLE:  state_d = DS_IDLE;
			DS_CHECK: state_d = (rem_q >= dvs_q) ? DS_DONE : DS_RUN;
			DS_RUN:   if (cnt_q == 7'd1) state_d = DS_DONE;
			DS_DONE:  state_d = DS_IDLE;
			default:  state_d = DS_IDLE;
		endcase
		if (req.start) state_d = DS_CHECK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DS_IDLE;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (req.start) begin
				cnt_q <= req.iters;
				ovf_q <= 1'b0;
			end else if (state_q == DS_CHECK) begin
				ovf_q <= (rem_q >= dvs_q);
			end else if (state_q == DS_RUN) begin
				cnt_q <= cnt_q - 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.rem;
			bits_q <= req.bits;
			dvs_q  <= req.divisor;
			quot_q <= '0;
		end else if (state_q == DS_RUN) begin
			rem_q  <= fits ? (trial - dvs_q) : trial;
			quot_q <= {quot_q[62:0], fits};
			bits_q <= {bits_q[62:0], 1'b0};
		end
	end

	assign rsp.done = (state_q == DS_DONE);
	assign rsp.ovf  = ovf_q;
	assign rsp.quot = quot_q;

endmodule

`default_nettype wire

### hw/rtl/rational_fit_weighted_error.sv
// Top level: weighted squared residual of a rational model, summed over a point set.
//
//  channel | valid     | ready     | payload
//  --------+-----------+-----------+--------------------------------------------------
//  in      | in_valid  | in_ready  | log_moneyness, mid_value, bid_value, ask_value,
//          |           |           | last_point
//  out     | out_valid | out_ready | weighted_error, saturated, pole_hit
//  cfg     | cfg_valid | cfg_ready | cfg_index, cfg_data
//
// A point is taken only while idle, so the next waits until this one is through: it
// uses the shared 33x33 multiplier, then 40 + 64 iterations of the radix-2 divider.
// A pole skips both divisions; a divider overflow ends that division after its check.
// Reset clears coefficients, the running sum and flags; no clearing pass.
// A last point waits in its final step only while the previous result is untaken.
// cfg_ready is always high.
`default_nettype none

module rational_fit_weighted_error
	import rfwe_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] log_moneyness,
	input  wire logic [23:0] mid_value,
	input  wire logic [23:0] bid_value,
	input  wire logic [23:0] ask_value,
	input  wire logic        last_point,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [63:0]      weighted_error,
	output logic             saturated,
	output logic             pole_hit,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);

	rfwe_state_t state_q, state_d;
	mul_step_t   mul_cnt_q;
	div_req_t    div_req;
	div_rsp_t    div_rsp;
	logic        out_load;

	logic [31:0] coef_a_q, coef_b_q, coef_c_q, coef_d_q, coef_e_q;
	logic [63:0] sum_q;
	logic        sat_q;
	logic        pole_q;
	logic        out_valid_q;

	logic [15:0] k_q;
	logic [23:0] mid_q, bid_q, ask_q;
	logic        last_q;
	logic signed [65:0] prod_q;
	logic signed [32:0] mul_a, mul_b;
	logic [30:0] kk_q;
	logic [63:0] num_q, den_q;
	logic [63:0] nmag, dmag;
	logic        neg_q;
	logic [24:0] spread_q;
	logic [40:0] qmag_q;
	logic [42:0] resid_q;
	logic [42:0] rabs;
	logic        clamp;
	logic [31:0] r_q;
	logic [63:0] term_q;
	logic [64:0] sum_ext;
	logic [63:0] wout_q;
	logic        sat_out_q, pole_out_q;

	assign nmag    = num_q[63] ? (64'd0 - num_q) : num_q;
	assign dmag    = den_q[63] ? (64'd0 - den_q) : den_q;
	assign rabs    = resid_q[42] ? (43'd0 - resid_q) : resid_q;
	assign clamp   = (rabs > {11'd0, RES_CAP});
	assign sum_ext = {1'b0, sum_q} + {1'b0, term_q};

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_SQR) begin
			mul_a = {1'b0, r_q};
			mul_b = {1'b0, r_q};
		end else begin
			unique case (mul_cnt_q)
				MS_KK: begin
					mul_a = {{17{k_q[15]}}, k_q};
					mul_b = {{17{k_q[15]}}, k_q};
				end
				MS_BK: begin
					mul_a = {coef_b_q[31], coef_b_q};
					mul_b = {{17{k_q[15]}}, k_q};
				end
				MS_CKK: begin
					mul_a = {coef_c_q[31], coef_c_q};
					mul_b = {2'b00, kk_q};
				end
				MS_DK: begin
					mul_a = {coef_d_q[31], coef_d_q};
					mul_b = {{17{k_q[15]}}, k_q};
				end
				MS_EKK: begin
					mul_a = {coef_e_q[31], coef_e_q};
					mul_b = {2'b00, kk_q};
				end
				default: begin
					mul_a = '0;
					mul_b = '0;
				end
			endcase
		end
	end

	always_comb begin
		state_d  = state_q;
		div_req  = '0;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_MUL;
			ST_MUL:  if (mul_cnt_q == MS_DRAIN) state_d = ST_DIV1_GO;
			ST_DIV1_GO: begin
				if (den_q == '0) begin
					state_d = ST_FIN;
				end else begin
					div_req.start   = 1'b1;
					div_req.rem     = {20'd0, nmag[63:20]};
					div_req.bits    = {nmag[19:0], 44'd0};
					div_req.divisor = dmag;
					div_req.iters   = DIV1_ITERS;
					state_d         = ST_DIV1;
				end
			end
			ST_DIV1: if (div_rsp.done) state_d = ST_SGN;
			ST_SGN:  state_d = ST_ABS;
			ST_ABS:  state_d = ST_SQR;
			ST_SQR:  state_d = ST_DIV2_GO;
			ST_DIV2_GO: begin
				div_req.start   = 1'b1;
				div_req.rem     = {52'd0, prod_q[63:52]};
				div_req.bits    = {prod_q[51:0], 12'd0};
				div_req.divisor = {39'd0, spread_q};
				div_req.iters   = DIV2_ITERS;
				state_d         = ST_DIV2;
			end
			ST_DIV2: if (div_rsp.done) state_d = ST_ACC;
			ST_ACC:  state_d = ST_FIN;
			ST_FIN: begin
				if (!last_q) begin
					state_d = ST_IDLE;
				end else if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mul_cnt_q   <= MS_KK;
			coef_a_q    <= '0;
			coef_b_q    <= '0;
			coef_c_q    <= '0;
			coef_d_q    <= '0;
			coef_e_q    <= '0;
			sum_q       <= '0;
			sat_q       <= 1'b0;
			pole_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_COEF_A: coef_a_q <= cfg_data;
					REG_COEF_B: coef_b_q <= cfg_data;
					REG_COEF_C: coef_c_q <= cfg_data;
					REG_COEF_D: coef_d_q <= cfg_data;
					REG_COEF_E: coef_e_q <= cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				mul_cnt_q <= MS_KK;
			end else if (state_q == ST_MUL && mul_cnt_q != MS_DRAIN) begin
				mul_cnt_q <= mul_step_t'(mul_cnt_q + 3'd1);
			end
			if (state_q == ST_DIV1_GO && den_q == '0) pole_q <= 1'b1;
			if (state_q == ST_ABS && clamp) sat_q <= 1'b1;
			if (state_q == ST_DIV2 && div_rsp.done && div_rsp.ovf) sat_q <= 1'b1;
			if (state_q == ST_ACC) begin
				if (sum_ext[64]) begin
					sum_q <= '1;
					sat_q <= 1'b1;
				end else begin
					sum_q <= sum_ext[63:0];
				end
			end
			if (out_load) begin
				sum_q  <= '0;
				sat_q  <= 1'b0;
				pole_q <= 1'b0;
			end
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (in_valid && in_ready) begin
			k_q    <= log_moneyness;
			mid_q  <= mid_value;
			bid_q  <= bid_value;
			ask_q  <= ask_value;
			last_q <= last_point;
			num_q  <= {{8{coef_a_q[31]}}, coef_a_q, 24'd0};
			den_q  <= DEN_ONE;
		end
		if (state_q == ST_MUL) begin
			unique case (mul_cnt_q)
				MS_KK:    ;
				MS_BK:    kk_q  <= prod_q[30:0];
				MS_CKK:   num_q <= num_q + {prod_q[51:0], 12'd0};
				MS_DK:    num_q <= num_q + prod_q[63:0];
				MS_EKK:   den_q <= den_q + {prod_q[51:0], 12'd0};
				MS_DRAIN: den_q <= den_q + prod_q[63:0];
				default:  ;
			endcase
		end
		if (state_q == ST_DIV1_GO) begin
			neg_q    <= num_q[63] ^ den_q[63];
			spread_q <= (ask_q >= bid_q) ? ({1'b0, ask_q} - {1'b0, bid_q} + 25'd1) : 25'd1;
		end
		if (state_q == ST_DIV1 && div_rsp.done) begin
			qmag_q <= div_rsp.ovf ? MODEL_CAP : div_rsp.quot[40:0];
		end
		if (state_q == ST_SGN) begin
			resid_q <= neg_q ? (43'd0 - {2'b00, qmag_q} - {19'd0, mid_q})
			                 : ({2'b00, qmag_q} - {19'd0, mid_q});
		end
		if (state_q == ST_ABS) begin
			r_q <= clamp ? RES_CAP : rabs[31:0];
		end
		if (state_q == ST_DIV2 && div_rsp.done) begin
			term_q <= div_rsp.ovf ? '1 : div_rsp.quot;
		end
		if (out_load) begin
			wout_q     <= sum_q;
			sat_out_q  <= sat_q;
			pole_out_q <= pole_q;
		end
	end

	rfwe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_ready       = (state_q == ST_IDLE);
	assign cfg_ready      = 1'b1;
	assign out_valid      = out_valid_q;
	assign weighted_error = wout_q;
	assign saturated      = sat_out_q;
	assign pole_hit       = pole_out_q;

	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV1 || state_q == ST_DIV2))
		else $error("divider finished with no division pending");

	a_ratio_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV1 && div_rsp.done && !div_rsp.ovf) |-> (div_rsp.quot[63:40] == '0))
		else $error("model ratio exceeds its range without overflow");

	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (sum_q == '0 && !sat_q && !pole_q && out_valid_q))
		else $error("running state not cleared after result");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !out_load)
		else $error("result overwritten before it was taken");

endmodule

`default_nettype wire
